/* sv/lvcp_pkg.sv */
// Package for the line view, clip and projection block.
// Holds the word types, register indexes and fixed-point constants.
// Depends on nothing.
`timescale 1ns / 1ps

package lvcp_pkg;

   typedef struct packed {
      logic signed [23:0] start_x;
      logic signed [23:0] start_y;
      logic signed [23:0] start_z;
      logic signed [23:0] end_x;
      logic signed [23:0] end_y;
      logic signed [23:0] end_z;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } req_word_type;

   typedef struct packed {
      logic               visible;
      logic signed [15:0] screen_x0;
      logic signed [15:0] screen_y0;
      logic signed [15:0] screen_x1;
      logic signed [15:0] screen_y1;
      logic [7:0]         out_red;
      logic [7:0]         out_green;
      logic [7:0]         out_blue;
   } rsp_word_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_CAM_POS_X   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAM_POS_Y   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAM_POS_Z   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_AXIS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UP_AXIS     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_AXIS   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOCAL_SCALE = 3'd6;

   localparam logic [11:0]        FOCAL_RESET = 12'd900;
   localparam logic signed [27:0] NEAR_Q8     = 28'sd26;
   localparam logic signed [19:0] CENTER_X    = 20'sd960;
   localparam logic signed [19:0] CENTER_Y    = 20'sd540;

endpackage

/* sv/lvcp_div_pipe.sv */
// Pipelined unsigned divider, one quotient bit per stage, rounded to nearest.
// Result is signed by a sign bit that travels with the operands.
// Depends on nothing.
`timescale 1ns / 1ps

module lvcp_div_pipe #(
   parameter int NW = 56,
   parameter int DW = 28,
   parameter int QW = 28
) (
   input  logic                  clock,
   input  logic [NW-1:0]         in_mag,
   input  logic [DW-1:0]         in_div,
   input  logic                  in_neg,
   output logic signed [QW+1:0]  out_quo
);

   // The dividend must be below the divisor times two to the power QW.
   logic [DW-1:0] rem_ff [QW+1];
   logic [QW-1:0] low_ff [QW+1];
   logic [QW-1:0] quo_ff [QW+1];
   logic [DW-1:0] div_ff [QW+1];
   logic          neg_ff [QW+1];
   logic signed [QW+1:0] out_ff;

   always_ff @(posedge clock) begin
      rem_ff[0] <= DW'(in_mag[NW-1:QW]);
      low_ff[0] <= in_mag[QW-1:0];
      quo_ff[0] <= '0;
      div_ff[0] <= in_div;
      neg_ff[0] <= in_neg;
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;
      assign trial = {rem_ff[k], low_ff[k][QW-1]};
      assign diff  = trial - {1'b0, div_ff[k]};
      assign ge    = trial >= {1'b0, div_ff[k]};
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
         low_ff[k+1] <= low_ff[k] << 1;
         quo_ff[k+1] <= {quo_ff[k][QW-2:0], ge};
         div_ff[k+1] <= div_ff[k];
         neg_ff[k+1] <= neg_ff[k];
      end
   end

   logic          round_up;
   logic [QW:0]   mag_in;
   logic signed [QW+1:0] quo_in;

   always_comb begin
      round_up = {rem_ff[QW], 1'b0} >= {1'b0, div_ff[QW]};
      mag_in   = {1'b0, quo_ff[QW]} + (QW+1)'(round_up);
      quo_in   = neg_ff[QW] ? -$signed({1'b0, mag_in}) : $signed({1'b0, mag_in});
   end

   always_ff @(posedge clock) begin
      out_ff <= quo_in;
   end

   assign out_quo = out_ff;

endmodule

/* sv/line_view_clip_project_top.sv */
// Top level of the line view transform, near-plane clip and projection block.
// Uses lvcp_pkg and lvcp_div_pipe.
`timescale 1ns / 1ps

// One segment word is taken in every cycle and its result word appears with rsp_valid
// high for one cycle; busy is always low. Each word passes through two pipelined
// dividers, the clip divider (28 quotient bits) and the projection divider (17 quotient
// bits), and through ten stages of transform, multiply and saturation logic. The
// receiver cannot stall the block, and results leave in the order segments came in.
// Registers are to be written through the csr port only while no segment is in flight;
// this binds the user, as the block itself does not enforce it.
module line_view_clip_project_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  lvcp_pkg::req_word_type               req_word,
   output logic                                 rsp_valid,
   output lvcp_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_we,
   input  logic [lvcp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lvcp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CLIP_QW   = 28;
   localparam int PROJ_QW   = 17;
   localparam int CLIP_LAT  = CLIP_QW + 2;
   localparam int PROJ_LAT  = PROJ_QW + 2;
   localparam int TOTAL_LAT = 10 + CLIP_LAT + PROJ_LAT;

   typedef struct packed {
      logic signed [27:0] px;
      logic signed [27:0] py;
      logic signed [27:0] pz;
      logic signed [27:0] qx;
      logic signed [27:0] qy;
      logic signed [27:0] qz;
      logic               pb;
      logic               qb;
      logic [23:0]        col;
   } clip_side_type;

   typedef struct packed {
      logic [3:0]  ovf;
      logic [3:0]  neg;
      logic        vis;
      logic [23:0] col;
   } proj_side_type;

   // Configuration registers.
   logic signed [23:0] cam_ff [3];
   logic [47:0]        right_ff;
   logic [47:0]        up_ff;
   logic [47:0]        view_ff;
   logic [11:0]        focal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff[0] <= '0;
         cam_ff[1] <= '0;
         cam_ff[2] <= '0;
         right_ff  <= '0;
         up_ff     <= '0;
         view_ff   <= '0;
         focal_ff  <= lvcp_pkg::FOCAL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lvcp_pkg::CSR_CAM_POS_X:   cam_ff[0] <= csr_wdata[23:0];
            lvcp_pkg::CSR_CAM_POS_Y:   cam_ff[1] <= csr_wdata[23:0];
            lvcp_pkg::CSR_CAM_POS_Z:   cam_ff[2] <= csr_wdata[23:0];
            lvcp_pkg::CSR_RIGHT_AXIS:  right_ff  <= csr_wdata[47:0];
            lvcp_pkg::CSR_UP_AXIS:     up_ff     <= csr_wdata[47:0];
            lvcp_pkg::CSR_VIEW_AXIS:   view_ff   <= csr_wdata[47:0];
            lvcp_pkg::CSR_FOCAL_SCALE: focal_ff  <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic signed [23:0] pt_in [2][3];
   logic signed [15:0] axis_h [3][3];

   always_comb begin
      pt_in[0][0] = req_word.start_x;
      pt_in[0][1] = req_word.start_y;
      pt_in[0][2] = req_word.start_z;
      pt_in[1][0] = req_word.end_x;
      pt_in[1][1] = req_word.end_y;
      pt_in[1][2] = req_word.end_z;
      for (int c = 0; c < 3; c++) begin
         axis_h[0][c] = right_ff[16*c +: 16];
         axis_h[1][c] = up_ff[16*c +: 16];
         axis_h[2][c] = view_ff[16*c +: 16];
      end
   end

   // Stage 1: camera minus point.
   logic               s1_valid_ff;
   logic signed [24:0] s1_d_ff [2][3];
   logic [23:0]        s1_col_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start & ~busy;
      for (int e = 0; e < 2; e++) begin
         for (int c = 0; c < 3; c++) begin
            s1_d_ff[e][c] <= 25'(cam_ff[c]) - 25'(pt_in[e][c]);
         end
      end
      s1_col_ff <= {req_word.red, req_word.green, req_word.blue};
   end

   // Stage 2: axis products.
   logic               s2_valid_ff;
   logic signed [40:0] s2_p_ff [2][3][3];
   logic [23:0]        s2_col_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      for (int e = 0; e < 2; e++) begin
         for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
               s2_p_ff[e][a][c] <= s1_d_ff[e][c] * axis_h[a][c];
            end
         end
      end
      s2_col_ff <= s1_col_ff;
   end

   // Stage 3: dot product sums.
   logic               s3_valid_ff;
   logic signed [42:0] s3_s_ff [2][3];
   logic [23:0]        s3_col_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
      for (int e = 0; e < 2; e++) begin
         for (int a = 0; a < 3; a++) begin
            s3_s_ff[e][a] <= 43'(s2_p_ff[e][a][0]) + 43'(s2_p_ff[e][a][1])
                             + 43'(s2_p_ff[e][a][2]);
         end
      end
      s3_col_ff <= s2_col_ff;
   end

   // Stage 4: round to Q.8 camera coordinates, ties away from zero.
   logic               s4_valid_ff;
   logic signed [27:0] s4_c_ff [2][3];
   logic [23:0]        s4_col_ff;
   logic signed [27:0] s4_c_in [2][3];

   always_comb begin
      logic [42:0] mag;
      logic [28:0] r;
      for (int e = 0; e < 2; e++) begin
         for (int a = 0; a < 3; a++) begin
            mag = s3_s_ff[e][a][42] ? 43'(-s3_s_ff[e][a]) : 43'(s3_s_ff[e][a]);
            r   = 29'((mag + 43'd8192) >> 14);
            s4_c_in[e][a] = s3_s_ff[e][a][42] ? 28'(-$signed(r)) : 28'($signed(r));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else       s4_valid_ff <= s3_valid_ff;
      s4_c_ff   <= s4_c_in;
      s4_col_ff <= s3_col_ff;
   end

   // Stage 5: near-plane test and clip operands.
   logic               s5_valid_ff;
   clip_side_type      s5_side_ff;
   logic signed [28:0] s5_dx_ff;
   logic signed [28:0] s5_dy_ff;
   logic signed [28:0] s5_num_ff;
   logic signed [28:0] s5_den_ff;
   clip_side_type      s5_side_in;
   logic signed [28:0] s5_dx_in;
   logic signed [28:0] s5_dy_in;
   logic signed [28:0] s5_num_in;
   logic signed [28:0] s5_den_in;

   always_comb begin
      logic pb;
      logic qb;
      logic signed [27:0] b [3];
      logic signed [27:0] f [3];
      pb = s4_c_ff[0][2] < lvcp_pkg::NEAR_Q8;
      qb = s4_c_ff[1][2] < lvcp_pkg::NEAR_Q8;
      for (int a = 0; a < 3; a++) begin
         b[a] = pb ? s4_c_ff[0][a] : s4_c_ff[1][a];
         f[a] = pb ? s4_c_ff[1][a] : s4_c_ff[0][a];
      end
      s5_side_in.px  = s4_c_ff[0][0];
      s5_side_in.py  = s4_c_ff[0][1];
      s5_side_in.pz  = s4_c_ff[0][2];
      s5_side_in.qx  = s4_c_ff[1][0];
      s5_side_in.qy  = s4_c_ff[1][1];
      s5_side_in.qz  = s4_c_ff[1][2];
      s5_side_in.pb  = pb;
      s5_side_in.qb  = qb;
      s5_side_in.col = s4_col_ff;
      s5_dx_in  = 29'(f[0]) - 29'(b[0]);
      s5_dy_in  = 29'(f[1]) - 29'(b[1]);
      s5_num_in = (pb ^ qb) ? 29'(lvcp_pkg::NEAR_Q8) - 29'(b[2]) : '0;
      s5_den_in = (pb ^ qb) ? 29'(f[2]) - 29'(b[2]) : 29'sd1;
   end

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else       s5_valid_ff <= s4_valid_ff;
      s5_side_ff <= s5_side_in;
      s5_dx_ff   <= s5_dx_in;
      s5_dy_ff   <= s5_dy_in;
      s5_num_ff  <= s5_num_in;
      s5_den_ff  <= s5_den_in;
   end

   // Stage 6: clip numerators.
   logic               s6_valid_ff;
   clip_side_type      s6_side_ff;
   logic signed [57:0] s6_mx_ff;
   logic signed [57:0] s6_my_ff;
   logic [27:0]        s6_den_ff;

   always_ff @(posedge clock) begin
      if (reset) s6_valid_ff <= 1'b0;
      else       s6_valid_ff <= s5_valid_ff;
      s6_side_ff <= s5_side_ff;
      s6_mx_ff   <= s5_dx_ff * s5_num_ff;
      s6_my_ff   <= s5_dy_ff * s5_num_ff;
      s6_den_ff  <= s5_den_ff[27:0];
   end

   logic [57:0] clip_mx_abs;
   logic [57:0] clip_my_abs;
   logic signed [CLIP_QW+1:0] clip_qx;
   logic signed [CLIP_QW+1:0] clip_qy;

   assign clip_mx_abs = s6_mx_ff[57] ? 58'(-s6_mx_ff) : 58'(s6_mx_ff);
   assign clip_my_abs = s6_my_ff[57] ? 58'(-s6_my_ff) : 58'(s6_my_ff);

   lvcp_div_pipe #(.NW(56), .DW(28), .QW(CLIP_QW)) u_clip_div_x (
      .clock   (clock),
      .in_mag  (clip_mx_abs[55:0]),
      .in_div  (s6_den_ff),
      .in_neg  (s6_mx_ff[57]),
      .out_quo (clip_qx)
   );

   lvcp_div_pipe #(.NW(56), .DW(28), .QW(CLIP_QW)) u_clip_div_y (
      .clock   (clock),
      .in_mag  (clip_my_abs[55:0]),
      .in_div  (s6_den_ff),
      .in_neg  (s6_my_ff[57]),
      .out_quo (clip_qy)
   );

   logic          l1_valid_ff [CLIP_LAT];
   clip_side_type l1_side_ff  [CLIP_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLIP_LAT; i++) l1_valid_ff[i] <= 1'b0;
      end else begin
         l1_valid_ff[0] <= s6_valid_ff;
         for (int i = 1; i < CLIP_LAT; i++) l1_valid_ff[i] <= l1_valid_ff[i-1];
      end
      l1_side_ff[0] <= s6_side_ff;
      for (int i = 1; i < CLIP_LAT; i++) l1_side_ff[i] <= l1_side_ff[i-1];
   end

   // Stage 8: move the endpoint behind the near plane onto it.
   logic               s8_valid_ff;
   logic signed [27:0] s8_c_ff [2][3];
   logic               s8_vis_ff;
   logic [23:0]        s8_col_ff;
   logic signed [27:0] s8_c_in [2][3];

   always_comb begin
      clip_side_type sd;
      logic signed [27:0] bx;
      logic signed [27:0] by;
      logic signed [29:0] nx;
      logic signed [29:0] ny;
      sd = l1_side_ff[CLIP_LAT-1];
      bx = sd.pb ? sd.px : sd.qx;
      by = sd.pb ? sd.py : sd.qy;
      nx = 30'(bx) + clip_qx;
      ny = 30'(by) + clip_qy;
      s8_c_in[0][0] = sd.px;
      s8_c_in[0][1] = sd.py;
      s8_c_in[0][2] = sd.pz;
      s8_c_in[1][0] = sd.qx;
      s8_c_in[1][1] = sd.qy;
      s8_c_in[1][2] = sd.qz;
      if (sd.pb && !sd.qb) begin
         s8_c_in[0][0] = nx[27:0];
         s8_c_in[0][1] = ny[27:0];
         s8_c_in[0][2] = lvcp_pkg::NEAR_Q8;
      end else if (sd.qb && !sd.pb) begin
         s8_c_in[1][0] = nx[27:0];
         s8_c_in[1][1] = ny[27:0];
         s8_c_in[1][2] = lvcp_pkg::NEAR_Q8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s8_valid_ff <= 1'b0;
      else       s8_valid_ff <= l1_valid_ff[CLIP_LAT-1];
      s8_c_ff   <= s8_c_in;
      s8_vis_ff <= ~(l1_side_ff[CLIP_LAT-1].pb & l1_side_ff[CLIP_LAT-1].qb);
      s8_col_ff <= l1_side_ff[CLIP_LAT-1].col;
   end

   // Stage 9: scale by focal length.
   logic               s9_valid_ff;
   logic signed [39:0] s9_m_ff [4];
   logic [26:0]        s9_z_ff [2];
   logic               s9_vis_ff;
   logic [23:0]        s9_col_ff;

   always_ff @(posedge clock) begin
      if (reset) s9_valid_ff <= 1'b0;
      else       s9_valid_ff <= s8_valid_ff;
      for (int e = 0; e < 2; e++) begin
         s9_m_ff[2*e]   <= s8_c_ff[e][0] * $signed({1'b0, focal_ff});
         s9_m_ff[2*e+1] <= s8_c_ff[e][1] * $signed({1'b0, focal_ff});
         s9_z_ff[e]     <= s8_c_ff[e][2][26:0];
      end
      s9_vis_ff <= s8_vis_ff;
      s9_col_ff <= s8_col_ff;
   end

   // Stage 10: magnitudes and early saturation check.
   logic               s10_valid_ff;
   logic [38:0]        s10_mag_ff [4];
   logic [26:0]        s10_z_ff [2];
   proj_side_type      s10_side_ff;
   logic [38:0]        s10_mag_in [4];
   proj_side_type      s10_side_in;

   always_comb begin
      logic [38:0] mag;
      logic        ovf;
      s10_side_in.vis = s9_vis_ff;
      s10_side_in.col = s9_col_ff;
      for (int i = 0; i < 4; i++) begin
         mag = s9_m_ff[i][39] ? 39'(-s9_m_ff[i]) : 39'(s9_m_ff[i]);
         ovf = {5'b0, mag} >= {s9_z_ff[i >> 1], 17'b0};
         s10_side_in.neg[i] = s9_m_ff[i][39];
         s10_side_in.ovf[i] = ovf;
         s10_mag_in[i]      = ovf ? '0 : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s10_valid_ff <= 1'b0;
      else       s10_valid_ff <= s9_valid_ff;
      s10_mag_ff  <= s10_mag_in;
      s10_z_ff    <= s9_z_ff;
      s10_side_ff <= s10_side_in;
   end

   logic signed [PROJ_QW+1:0] proj_q [4];

   for (genvar i = 0; i < 4; i++) begin : g_proj
      lvcp_div_pipe #(.NW(39), .DW(27), .QW(PROJ_QW)) u_proj_div (
         .clock   (clock),
         .in_mag  (s10_mag_ff[i]),
         .in_div  (s10_z_ff[i >> 1]),
         .in_neg  (s10_side_ff.neg[i]),
         .out_quo (proj_q[i])
      );
   end

   logic          l2_valid_ff [PROJ_LAT];
   proj_side_type l2_side_ff  [PROJ_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PROJ_LAT; i++) l2_valid_ff[i] <= 1'b0;
      end else begin
         l2_valid_ff[0] <= s10_valid_ff;
         for (int i = 1; i < PROJ_LAT; i++) l2_valid_ff[i] <= l2_valid_ff[i-1];
      end
      l2_side_ff[0] <= s10_side_ff;
      for (int i = 1; i < PROJ_LAT; i++) l2_side_ff[i] <= l2_side_ff[i-1];
   end

   // Output stage: offset from screen center and saturate.
   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767)       r = 16'sh7FFF;
      else if (v < -20'sd32768) r = -16'sh8000;
      else                      r = v[15:0];
      return r;
   endfunction

   logic                  rsp_valid_ff;
   lvcp_pkg::rsp_word_type rsp_word_ff;
   lvcp_pkg::rsp_word_type rsp_word_in;

   always_comb begin
      proj_side_type sd;
      logic signed [PROJ_QW+1:0] o [4];
      logic signed [15:0] s [4];
      sd = l2_side_ff[PROJ_LAT-1];
      for (int i = 0; i < 4; i++) begin
         if (sd.ovf[i]) begin
            o[i] = sd.neg[i] ? -(PROJ_QW+2)'(1 << PROJ_QW) : (PROJ_QW+2)'(1 << PROJ_QW);
         end else begin
            o[i] = proj_q[i];
         end
      end
      s[0] = sat16(lvcp_pkg::CENTER_X + 20'(o[0]));
      s[1] = sat16(lvcp_pkg::CENTER_Y - 20'(o[1]));
      s[2] = sat16(lvcp_pkg::CENTER_X + 20'(o[2]));
      s[3] = sat16(lvcp_pkg::CENTER_Y - 20'(o[3]));
      rsp_word_in.visible   = sd.vis;
      rsp_word_in.screen_x0 = sd.vis ? s[0] : '0;
      rsp_word_in.screen_y0 = sd.vis ? s[1] : '0;
      rsp_word_in.screen_x1 = sd.vis ? s[2] : '0;
      rsp_word_in.screen_y1 = sd.vis ? s[3] : '0;
      rsp_word_in.out_red   = sd.col[23:16];
      rsp_word_in.out_green = sd.col[15:8];
      rsp_word_in.out_blue  = sd.col[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= l2_valid_ff[PROJ_LAT-1];
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Every accepted word comes out after the fixed latency, and nothing else does.
   a_latency_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##TOTAL_LAT rsp_valid)
      else $error("accepted word did not emerge at the fixed latency");

   a_latency_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, TOTAL_LAT))
      else $error("result word without a matching accepted word");

   a_dropped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.visible) |->
         (rsp_word.screen_x0 == '0 && rsp_word.screen_y0 == '0 &&
          rsp_word.screen_x1 == '0 && rsp_word.screen_y1 == '0))
      else $error("dropped segment carries nonzero screen coordinates");

   a_clip_depth: assert property (@(posedge clock) disable iff (reset)
      (s8_valid_ff && s8_vis_ff) |->
         (s8_c_ff[0][2] >= lvcp_pkg::NEAR_Q8 && s8_c_ff[1][2] >= lvcp_pkg::NEAR_Q8))
      else $error("visible endpoint left behind the near plane after clipping");

endmodule
